>>> design/ctb_pkg.sv
`default_nettype none
package ctb_pkg;

	// field widths
	localparam int VEL_W    = 20;
	localparam int RAD_W    = 24;
	localparam int DEP_W    = 18;
	localparam int SLOPE_W  = 20;
	localparam int FRAC_W   = 16;
	localparam int HW_W     = 18;
	localparam int WID_W    = 19;
	localparam int NUM_W    = 40;
	localparam int QUO_W    = 20;
	localparam int LANES    = 5;
	localparam int COEF_W   = 18;
	localparam int CFG_IW   = 2;
	localparam int CFG_DW   = 24;

	// divider: quotient bits resolved per stage
	localparam int DIV_BITS   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_BITS;

	// lane order of the velocity vector
	localparam int LANE_VSV = 0;
	localparam int LANE_VSH = 1;
	localparam int LANE_VPV = 2;
	localparam int LANE_VPH = 3;
	localparam int LANE_RHO = 4;

	// crustal scalings, Q2.16 slope and Q2.16 intercept
	localparam logic [COEF_W-1:0] CONT_VP_A   = 18'd100919;
	localparam logic [COEF_W-1:0] CONT_VP_B   = 18'd55050;
	localparam logic [COEF_W-1:0] CONT_RHO_A  = 18'd14923;
	localparam logic [COEF_W-1:0] CONT_RHO_B  = 18'd132121;
	localparam logic [COEF_W-1:0] OCEAN_VP_A  = 18'd103973;
	localparam logic [COEF_W-1:0] OCEAN_VP_B  = 18'd55312;
	localparam logic [COEF_W-1:0] OCEAN_RHO_A = 18'd16692;
	localparam logic [COEF_W-1:0] OCEAN_RHO_B = 18'd129696;

	// register reset values
	localparam logic [RAD_W-1:0]   RST_EARTH_RADIUS = 24'd6523904;
	localparam logic [RAD_W-1:0]   RST_ANISO_RADIUS = 24'd6339584;
	localparam logic [SLOPE_W-1:0] RST_ANISO_SLOPE  = 20'd18455;
	localparam logic [FRAC_W-1:0]  RST_TAPER_FRAC   = 16'd16384;

	typedef logic [VEL_W-1:0] vel_t;
	typedef vel_t [LANES-1:0] vel5_t;

	typedef enum logic [1:0] {
		REG_MANTLE = 2'd0,
		REG_CRUST  = 2'd1,
		REG_BLEND  = 2'd2
	} region_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_EARTH_RADIUS = 2'd0,
		CFG_ANISO_RADIUS = 2'd1,
		CFG_ANISO_SLOPE  = 2'd2,
		CFG_TAPER_FRAC   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [RAD_W-1:0]   earth_radius;
		logic [RAD_W-1:0]   aniso_radius;
		logic [SLOPE_W-1:0] aniso_slope;
		logic [FRAC_W-1:0]  taper_frac;
	} cfg_t;

	typedef struct packed {
		logic [RAD_W-1:0] radius;
		logic [DEP_W-1:0] crust_depth;
		vel_t             vs;
		logic             oceanic;
		vel5_t            mant;
		logic             last;
	} pt_t;

	// front end result: crustal and mantle values plus band position
	typedef struct packed {
		vel5_t            crust;
		vel5_t            mant;
		logic [WID_W-1:0] offs;
		logic [WID_W-1:0] width;
		logic [HW_W-1:0]  hw;
		region_t          region;
		logic             last;
	} front_t;

	// travels alongside the divider
	typedef struct packed {
		vel5_t   pass;
		region_t region;
		logic    last;
	} side_t;

	// clamp a signed value to the velocity range
	function automatic vel_t sat_vel(input logic signed [27:0] v);
		vel_t r;
		if (v[27]) begin
			r = '0;
		end else if (|v[26:VEL_W]) begin
			r = '1;
		end else begin
			r = v[VEL_W-1:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/ctb_in_if.sv
`default_nettype none
interface ctb_in_if;
	logic                      valid;
	logic                      ready;
	logic [ctb_pkg::RAD_W-1:0] radius;
	logic [ctb_pkg::DEP_W-1:0] crust_depth;
	ctb_pkg::vel_t             crust_shear_vel;
	logic                      oceanic;
	ctb_pkg::vel_t             vsv_in;
	ctb_pkg::vel_t             vsh_in;
	ctb_pkg::vel_t             vpv_in;
	ctb_pkg::vel_t             vph_in;
	ctb_pkg::vel_t             density_in;
	logic                      last_point;

	modport source (
		output valid, radius, crust_depth, crust_shear_vel, oceanic,
		output vsv_in, vsh_in, vpv_in, vph_in, density_in, last_point,
		input  ready
	);
	modport sink (
		input  valid, radius, crust_depth, crust_shear_vel, oceanic,
		input  vsv_in, vsh_in, vpv_in, vph_in, density_in, last_point,
		output ready
	);
endinterface
`default_nettype wire

>>> design/ctb_out_if.sv
`default_nettype none
interface ctb_out_if;
	logic              valid;
	logic              ready;
	ctb_pkg::vel_t     vsv_out;
	ctb_pkg::vel_t     vsh_out;
	ctb_pkg::vel_t     vpv_out;
	ctb_pkg::vel_t     vph_out;
	ctb_pkg::vel_t     density_out;
	ctb_pkg::region_t  region;
	logic              last_out;

	modport source (
		output valid, vsv_out, vsh_out, vpv_out, vph_out, density_out,
		output region, last_out,
		input  ready
	);
	modport sink (
		input  valid, vsv_out, vsh_out, vpv_out, vph_out, density_out,
		input  region, last_out,
		output ready
	);
endinterface
`default_nettype wire

>>> design/ctb_front.sv
`default_nettype none
// Stages 1 to 3: band limits, region, anisotropy and crustal scalings
module ctb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ctb_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	input  wire ctb_pkg::pt_t  pt,
	output logic               out_valid,
	output ctb_pkg::front_t    out
);

	// ---- stage 1: half width, Moho, |r - r_ani|, scaling products
	logic [ctb_pkg::DEP_W+ctb_pkg::FRAC_W-1:0] hw_prod;
	logic signed [ctb_pkg::RAD_W:0]            d_ani;
	logic [ctb_pkg::COEF_W-1:0]                coef_vp, coef_rho;

	always_comb begin
		hw_prod  = (ctb_pkg::DEP_W+ctb_pkg::FRAC_W)'(pt.crust_depth)
			* (ctb_pkg::DEP_W+ctb_pkg::FRAC_W)'(cfg.taper_frac);
		d_ani    = $signed({1'b0, pt.radius}) - $signed({1'b0, cfg.aniso_radius});
		coef_vp  = pt.oceanic ? ctb_pkg::OCEAN_VP_A  : ctb_pkg::CONT_VP_A;
		coef_rho = pt.oceanic ? ctb_pkg::OCEAN_RHO_A : ctb_pkg::CONT_RHO_A;
	end

	logic                                      v_s1;
	logic [ctb_pkg::HW_W-1:0]                  hw_s1;
	logic signed [ctb_pkg::RAD_W+1:0]          moho_s1;
	logic [ctb_pkg::RAD_W-1:0]                 rad_s1, absd_s1;
	logic                                      dneg_s1, ocean_s1, last_s1;
	logic [ctb_pkg::VEL_W+ctb_pkg::COEF_W-1:0] pvp_s1, prho_s1;
	ctb_pkg::vel_t                             vs_s1;
	ctb_pkg::vel5_t                            mant_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hw_s1    <= hw_prod[ctb_pkg::DEP_W+ctb_pkg::FRAC_W-1:ctb_pkg::FRAC_W];
			moho_s1  <= $signed({2'b0, cfg.earth_radius})
				- $signed({(ctb_pkg::RAD_W+2-ctb_pkg::DEP_W)'(0), pt.crust_depth});
			rad_s1   <= pt.radius;
			dneg_s1  <= d_ani[ctb_pkg::RAD_W];
			absd_s1  <= d_ani[ctb_pkg::RAD_W] ? ctb_pkg::RAD_W'(-d_ani)
				: d_ani[ctb_pkg::RAD_W-1:0];
			pvp_s1   <= (ctb_pkg::VEL_W+ctb_pkg::COEF_W)'(pt.vs)
				* (ctb_pkg::VEL_W+ctb_pkg::COEF_W)'(coef_vp);
			prho_s1  <= (ctb_pkg::VEL_W+ctb_pkg::COEF_W)'(pt.vs)
				* (ctb_pkg::VEL_W+ctb_pkg::COEF_W)'(coef_rho);
			ocean_s1 <= pt.oceanic;
			vs_s1    <= pt.vs;
			mant_s1  <= pt.mant;
			last_s1  <= pt.last;
		end
	end

	// ---- stage 2: band limits, region, anisotropy product, rounding of the scalings
	localparam int PW = ctb_pkg::VEL_W + ctb_pkg::COEF_W;
	logic signed [ctb_pkg::RAD_W+1:0] rad_sx, bot, top, dist_full;
	logic [PW-1:0]                    rvp, rrho;
	logic [22:0]                      vp_sum, rho_sum;
	logic [ctb_pkg::COEF_W-1:0]       icpt_vp, icpt_rho;
	ctb_pkg::region_t                 region;

	always_comb begin
		rad_sx    = $signed({2'b0, rad_s1});
		bot       = moho_s1 - $signed({(ctb_pkg::RAD_W+2-ctb_pkg::HW_W)'(0), hw_s1});
		top       = moho_s1 + $signed({(ctb_pkg::RAD_W+2-ctb_pkg::HW_W)'(0), hw_s1});
		dist_full = rad_sx - bot;
		icpt_vp   = ocean_s1 ? ctb_pkg::OCEAN_VP_B  : ctb_pkg::CONT_VP_B;
		icpt_rho  = ocean_s1 ? ctb_pkg::OCEAN_RHO_B : ctb_pkg::CONT_RHO_B;
		rvp       = pvp_s1  + PW'(32768);
		rrho      = prho_s1 + PW'(32768);
		vp_sum    = 23'(rvp[PW-1:16])  + 23'(icpt_vp);
		rho_sum   = 23'(rrho[PW-1:16]) + 23'(icpt_rho);
		priority if (rad_sx < bot) begin
			region = ctb_pkg::REG_MANTLE;
		end else if (rad_sx > top || hw_s1 == '0) begin
			region = ctb_pkg::REG_CRUST;
		end else begin
			region = ctb_pkg::REG_BLEND;
		end
	end

	logic                                       v_s2, dneg_s2, last_s2;
	logic [ctb_pkg::RAD_W+ctb_pkg::SLOPE_W-1:0] ani_s2;
	ctb_pkg::region_t                           region_s2;
	logic [ctb_pkg::WID_W-1:0]                  dist_s2;
	logic [ctb_pkg::HW_W-1:0]                   hw_s2;
	ctb_pkg::vel_t                              vs_s2, vp_s2, rho_s2;
	ctb_pkg::vel5_t                             mant_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ani_s2    <= (ctb_pkg::RAD_W+ctb_pkg::SLOPE_W)'(absd_s1)
				* (ctb_pkg::RAD_W+ctb_pkg::SLOPE_W)'(cfg.aniso_slope);
			dneg_s2   <= dneg_s1;
			region_s2 <= region;
			dist_s2   <= dist_full[ctb_pkg::WID_W-1:0];
			hw_s2     <= hw_s1;
			vs_s2     <= vs_s1;
			vp_s2     <= ctb_pkg::sat_vel($signed({5'b0, vp_sum}));
			rho_s2    <= ctb_pkg::sat_vel($signed({5'b0, rho_sum}));
			mant_s2   <= mant_s1;
			last_s2   <= last_s1;
		end
	end

	// ---- stage 3: anisotropy term, shear velocities
	localparam int AW = ctb_pkg::RAD_W + ctb_pkg::SLOPE_W;
	logic [AW:0]                rani;
	logic [AW-19:0]             mag;
	logic signed [27:0]         vs_x, mag_x;
	ctb_pkg::vel5_t             crust;

	always_comb begin
		rani  = {1'b0, ani_s2} + (AW+1)'(262144);
		mag   = rani[AW:19];
		vs_x  = $signed({8'b0, vs_s2});
		mag_x = $signed({(28-(AW-18))'(0), mag});
		crust[ctb_pkg::LANE_VSV] = ctb_pkg::sat_vel(dneg_s2 ? vs_x + mag_x : vs_x - mag_x);
		crust[ctb_pkg::LANE_VSH] = ctb_pkg::sat_vel(dneg_s2 ? vs_x - mag_x : vs_x + mag_x);
		crust[ctb_pkg::LANE_VPV] = vp_s2;
		crust[ctb_pkg::LANE_VPH] = vp_s2;
		crust[ctb_pkg::LANE_RHO] = rho_s2;
	end

	logic            v_s3;
	ctb_pkg::front_t f_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s3.crust  <= crust;
			f_s3.mant   <= mant_s2;
			f_s3.offs   <= dist_s2;
			f_s3.width  <= {hw_s2, 1'b0};
			f_s3.hw     <= hw_s2;
			f_s3.region <= region_s2;
			f_s3.last   <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out       = f_s3;

	// a blended point lies within the band, and its band is never empty
	a_blend_dist: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && f_s3.region == ctb_pkg::REG_BLEND |-> f_s3.offs <= f_s3.width)
		else $error("blend distance beyond band width");
	a_blend_width: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && f_s3.width == '0 |-> f_s3.region != ctb_pkg::REG_BLEND)
		else $error("blend with zero-width band");

endmodule
`default_nettype wire

>>> design/ctb_blend.sv
`default_nettype none
// Stages 4 and 5: blend numerators for all five lanes
module ctb_blend (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire ctb_pkg::front_t f,
	output logic                 out_valid,
	output logic [ctb_pkg::LANES-1:0][ctb_pkg::NUM_W-1:0] num,
	output logic [ctb_pkg::WID_W-1:0] divisor,
	output ctb_pkg::side_t       side
);

	localparam int PW = ctb_pkg::VEL_W + ctb_pkg::WID_W;

	// ---- stage 4: crust * offset and mantle * (width - offset)
	logic [ctb_pkg::WID_W-1:0] wmd;
	assign wmd = f.width - f.offs;

	logic                                     v_s4;
	logic [ctb_pkg::LANES-1:0][PW-1:0]        pc_s4, pm_s4;
	logic [ctb_pkg::HW_W-1:0]                 hw_s4;
	logic [ctb_pkg::WID_W-1:0]                width_s4;
	ctb_pkg::side_t                           side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ctb_pkg::LANES; i++) begin
				pc_s4[i] <= PW'(f.crust[i]) * PW'(f.offs);
				pm_s4[i] <= PW'(f.mant[i]) * PW'(wmd);
			end
			hw_s4          <= f.hw;
			width_s4       <= f.width;
			side_s4.pass   <= (f.region == ctb_pkg::REG_MANTLE) ? f.mant : f.crust;
			side_s4.region <= f.region;
			side_s4.last   <= f.last;
		end
	end

	// ---- stage 5: sum with half-width rounding term
	logic                                               v_s5;
	logic [ctb_pkg::LANES-1:0][ctb_pkg::NUM_W-1:0]      num_s5;
	logic [ctb_pkg::WID_W-1:0]                          width_s5;
	ctb_pkg::side_t                                     side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ctb_pkg::LANES; i++) begin
				num_s5[i] <= ctb_pkg::NUM_W'(pc_s4[i]) + ctb_pkg::NUM_W'(pm_s4[i])
					+ ctb_pkg::NUM_W'(hw_s4);
			end
			width_s5 <= width_s4;
			side_s5  <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign num       = num_s5;
	assign divisor   = width_s5;
	assign side      = side_s5;

endmodule
`default_nettype wire

>>> design/ctb_div.sv
`default_nettype none
// Pipelined restoring divider, five lanes sharing one divisor,
// DIV_BITS quotient bits per stage. The quotient is known to fit QUO_W bits.
module ctb_div (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [ctb_pkg::LANES-1:0][ctb_pkg::NUM_W-1:0] num,
	input  wire logic [ctb_pkg::WID_W-1:0] divisor,
	input  wire ctb_pkg::side_t side,
	output logic                out_valid,
	output ctb_pkg::vel5_t      quot,
	output ctb_pkg::side_t      out_side
);

	localparam int NS = ctb_pkg::DIV_STAGES;
	localparam int RW = ctb_pkg::WID_W;
	localparam int QW = ctb_pkg::QUO_W;

	logic [NS-1:0]                               v_q;
	logic [ctb_pkg::LANES-1:0][RW-1:0]           rem_q  [NS];
	logic [ctb_pkg::LANES-1:0][QW-1:0]           quot_q [NS];
	logic [ctb_pkg::LANES-1:0][QW-1:0]           low_q  [NS];
	logic [RW-1:0]                               div_q  [NS];
	ctb_pkg::side_t                              side_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam int TOP = QW - 1 - k * ctb_pkg::DIV_BITS;

		logic                                     v_in;
		logic [ctb_pkg::LANES-1:0][RW-1:0]        rem_in, rem_nx;
		logic [ctb_pkg::LANES-1:0][QW-1:0]        quot_in, quot_nx, low_in;
		logic [RW-1:0]                            div_in;
		ctb_pkg::side_t                           side_in;

		if (k == 0) begin : g_first
			always_comb begin
				v_in    = in_valid;
				div_in  = divisor;
				side_in = side;
				quot_in = '0;
				for (int i = 0; i < ctb_pkg::LANES; i++) begin
					rem_in[i] = num[i][QW+RW-1:QW];
					low_in[i] = num[i][QW-1:0];
				end
			end
		end else begin : g_next
			always_comb begin
				v_in    = v_q[k-1];
				div_in  = div_q[k-1];
				side_in = side_q[k-1];
				quot_in = quot_q[k-1];
				rem_in  = rem_q[k-1];
				low_in  = low_q[k-1];
			end
		end

		// shift in a numerator bit, subtract where it fits
		always_comb begin
			logic [RW:0] t;
			rem_nx  = rem_in;
			quot_nx = quot_in;
			t       = '0;
			for (int i = 0; i < ctb_pkg::LANES; i++) begin
				for (int j = 0; j < ctb_pkg::DIV_BITS; j++) begin
					t = {rem_nx[i], low_in[i][TOP-j]};
					if (t >= {1'b0, div_in}) begin
						t                  = t - {1'b0, div_in};
						quot_nx[i][TOP-j]  = 1'b1;
					end
					rem_nx[i] = t[RW-1:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[k] <= 1'b0;
			else if (en) v_q[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= rem_nx;
				quot_q[k] <= quot_nx;
				low_q[k]  <= low_in;
				div_q[k]  <= div_in;
				side_q[k] <= side_in;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < ctb_pkg::LANES; i++) begin
			quot[i] = quot_q[NS-1][i];
		end
	end
	assign out_valid = v_q[NS-1];
	assign out_side  = side_q[NS-1];

	// a finished blend leaves the remainders of lanes 0 and 4 below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NS-1] && side_q[NS-1].region == ctb_pkg::REG_BLEND
		|-> rem_q[NS-1][0] < div_q[NS-1] && rem_q[NS-1][4] < div_q[NS-1])
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> design/crust_taper_blend.sv
// crust_taper_blend: overlays a crust on a stream of mantle model points.
// Points enter on channel pt (valid/ready); each gives exactly one result
// beat on channel res, in order. The block is a 15-stage pipeline plus an
// output register: 3 stages for band limits, region, anisotropy and crustal
// scalings, 2 stages for the blend products, and 10 stages of a pipelined
// restoring divider resolving 2 quotient bits per stage for all five lanes.
// One point is accepted every cycle while the receiver keeps up.
// When res is stalled with a beat waiting, the whole pipeline holds and
// pt.ready drops in the same cycle; nothing is lost or repeated.
// Configuration (cfg_we, cfg_index, cfg_data) writes one register per cycle
// and is applied to points entering afterwards; write it only while idle.
// Reset (arst_n low) empties the pipeline and restores the register
// defaults: 6371 km surface, 6191 km anisotropy radius, slope 0.0011 /km,
// taper fraction 0.25.
`default_nettype none
module crust_taper_blend (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	ctb_in_if.sink                           pt,
	ctb_out_if.source                        res,
	input  wire logic                        cfg_we,
	input  wire logic [ctb_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [ctb_pkg::CFG_DW-1:0]  cfg_data
);

	// advance when the output register is free or being emptied
	logic en;
	logic out_v_q;
	assign en       = !out_v_q || res.ready;
	assign pt.ready = en;

	// configuration registers
	ctb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.earth_radius <= ctb_pkg::RST_EARTH_RADIUS;
			cfg_q.aniso_radius <= ctb_pkg::RST_ANISO_RADIUS;
			cfg_q.aniso_slope  <= ctb_pkg::RST_ANISO_SLOPE;
			cfg_q.taper_frac   <= ctb_pkg::RST_TAPER_FRAC;
		end else if (cfg_we) begin
			unique case (ctb_pkg::cfg_idx_t'(cfg_index))
				ctb_pkg::CFG_EARTH_RADIUS: cfg_q.earth_radius <= cfg_data;
				ctb_pkg::CFG_ANISO_RADIUS: cfg_q.aniso_radius <= cfg_data;
				ctb_pkg::CFG_ANISO_SLOPE:
					cfg_q.aniso_slope <= cfg_data[ctb_pkg::SLOPE_W-1:0];
				ctb_pkg::CFG_TAPER_FRAC:
					cfg_q.taper_frac <= cfg_data[ctb_pkg::FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	// gather the input beat
	ctb_pkg::pt_t pt_d;
	always_comb begin
		pt_d.radius      = pt.radius;
		pt_d.crust_depth = pt.crust_depth;
		pt_d.vs          = pt.crust_shear_vel;
		pt_d.oceanic     = pt.oceanic;
		pt_d.mant[ctb_pkg::LANE_VSV] = pt.vsv_in;
		pt_d.mant[ctb_pkg::LANE_VSH] = pt.vsh_in;
		pt_d.mant[ctb_pkg::LANE_VPV] = pt.vpv_in;
		pt_d.mant[ctb_pkg::LANE_VPH] = pt.vph_in;
		pt_d.mant[ctb_pkg::LANE_RHO] = pt.density_in;
		pt_d.last        = pt.last_point;
	end

	logic            f_valid;
	ctb_pkg::front_t f;

	ctb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.in_valid  (pt.valid),
		.pt        (pt_d),
		.out_valid (f_valid),
		.out       (f)
	);

	logic                                          b_valid;
	logic [ctb_pkg::LANES-1:0][ctb_pkg::NUM_W-1:0] b_num;
	logic [ctb_pkg::WID_W-1:0]                     b_div;
	ctb_pkg::side_t                                b_side;

	ctb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (f_valid),
		.f         (f),
		.out_valid (b_valid),
		.num       (b_num),
		.divisor   (b_div),
		.side      (b_side)
	);

	logic           d_valid;
	ctb_pkg::vel5_t d_quot;
	ctb_pkg::side_t d_side;

	ctb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (b_valid),
		.num       (b_num),
		.divisor   (b_div),
		.side      (b_side),
		.out_valid (d_valid),
		.quot      (d_quot),
		.out_side  (d_side)
	);

	// output register: blend quotient or passed-through values
	ctb_pkg::vel5_t   vals_q;
	ctb_pkg::region_t region_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= d_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vals_q   <= (d_side.region == ctb_pkg::REG_BLEND) ? d_quot : d_side.pass;
			region_q <= d_side.region;
			last_q   <= d_side.last;
		end
	end

	assign res.valid       = out_v_q;
	assign res.vsv_out     = vals_q[ctb_pkg::LANE_VSV];
	assign res.vsh_out     = vals_q[ctb_pkg::LANE_VSH];
	assign res.vpv_out     = vals_q[ctb_pkg::LANE_VPV];
	assign res.vph_out     = vals_q[ctb_pkg::LANE_VPH];
	assign res.density_out = vals_q[ctb_pkg::LANE_RHO];
	assign res.region      = region_q;
	assign res.last_out    = last_q;

	// a waiting beat holds the whole pipeline
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !pt.ready)
		else $error("input taken while output stalled");

endmodule
`default_nettype wire

>>> tb/sv/crust_taper_blend_tb.sv
`timescale 1ns / 1ps
module crust_taper_blend_tb;
	import ctb_pkg::*;

	localparam longint VMAX      = 1048575;
	localparam longint RAD_MAX   = 16777215;
	localparam longint DEP_MAX   = 262143;
	localparam int     CYC_LIMIT = 400000;
	localparam int     DRAIN     = 40;

	typedef struct packed {
		vel5_t   v;
		region_t region;
		logic    last;
	} result_t;

	// model of the block plus the queue of results still owed
	class blend_scoreboard;
		longint    earth_r  = RST_EARTH_RADIUS;
		longint    aniso_r  = RST_ANISO_RADIUS;
		longint    slope    = RST_ANISO_SLOPE;
		longint    frac     = RST_TAPER_FRAC;
		result_t   owed[$];
		int        errors   = 0;

		function longint clamp_vel(longint v);
			return (v < 0) ? 0 : ((v > VMAX) ? VMAX : v);
		endfunction

		function longint lin_scale(longint vs, longint coef, longint icpt);
			return clamp_vel(((vs * coef + 32768) >>> 16) + icpt);
		endfunction

		function longint half_width(longint dep);
			return (dep * frac) >>> 16;
		endfunction

		function result_t overlay_point(pt_t p);
			longint rad, dep, vs, hw, bot, top, d, mag, ani, offs, width, num;
			longint crust [LANES];
			longint mant [LANES];
			result_t r;
			rad = p.radius;
			dep = p.crust_depth;
			vs  = p.vs;
			for (int i = 0; i < LANES; i++) mant[i] = p.mant[i];
			hw  = half_width(dep);
			bot = earth_r - dep - hw;
			top = earth_r - dep + hw;
			// anisotropy, rounded on the magnitude
			d   = rad - aniso_r;
			mag = ((d < 0 ? -d : d) * slope + 262144) >>> 19;
			ani = (d < 0) ? -mag : mag;
			crust[LANE_VSV] = clamp_vel(vs - ani);
			crust[LANE_VSH] = clamp_vel(vs + ani);
			if (p.oceanic) begin
				crust[LANE_VPV] = lin_scale(vs, OCEAN_VP_A, OCEAN_VP_B);
				crust[LANE_RHO] = lin_scale(vs, OCEAN_RHO_A, OCEAN_RHO_B);
			end else begin
				crust[LANE_VPV] = lin_scale(vs, CONT_VP_A, CONT_VP_B);
				crust[LANE_RHO] = lin_scale(vs, CONT_RHO_A, CONT_RHO_B);
			end
			crust[LANE_VPH] = crust[LANE_VPV];
			r.last = p.last;
			if (rad < bot) begin
				r.region = REG_MANTLE;
				for (int i = 0; i < LANES; i++) r.v[i] = mant[i];
			end else if (rad > top || hw == 0) begin
				r.region = REG_CRUST;
				for (int i = 0; i < LANES; i++) r.v[i] = crust[i];
			end else begin
				r.region = REG_BLEND;
				offs  = rad - bot;
				width = 2 * hw;
				for (int i = 0; i < LANES; i++) begin
					num    = crust[i] * offs + mant[i] * (width - offs) + width / 2;
					r.v[i] = (num / width) & VMAX;
				end
			end
			return r;
		endfunction

		function void note_point(pt_t p);
			owed.push_back(overlay_point(p));
		endfunction

		function void check_result(result_t got);
			result_t want;
			string   lane_name [LANES] = '{"vsv", "vsh", "vpv", "vph", "density"};
			if (owed.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, got);
				errors++;
				return;
			end
			want = owed.pop_front();
			for (int i = 0; i < LANES; i++)
				if (got.v[i] !== want.v[i]) begin
					$display("%0t: %s expected %0d actual %0d", $time, lane_name[i],
						want.v[i], got.v[i]);
					errors++;
				end
			if (got.region !== want.region) begin
				$display("%0t: region expected %0d actual %0d", $time, want.region,
					got.region);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	logic                quiet;
	int                  cycles;
	blend_scoreboard     sb;

	ctb_in_if  pt_if ();
	ctb_out_if res_if ();

	crust_taper_blend dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("crust_taper_blend_tb NOT OK");
			$finish;
		end
	end

	// beats are sampled mid-cycle, where every signal has settled
	always @(negedge clk) begin
		pt_t     p;
		result_t r;
		if (arst_n) begin
			if (pt_if.valid && pt_if.ready) begin
				p.radius      = pt_if.radius;
				p.crust_depth = pt_if.crust_depth;
				p.vs          = pt_if.crust_shear_vel;
				p.oceanic     = pt_if.oceanic;
				p.mant[LANE_VSV] = pt_if.vsv_in;
				p.mant[LANE_VSH] = pt_if.vsh_in;
				p.mant[LANE_VPV] = pt_if.vpv_in;
				p.mant[LANE_VPH] = pt_if.vph_in;
				p.mant[LANE_RHO] = pt_if.density_in;
				p.last        = pt_if.last_point;
				sb.note_point(p);
			end
			if (res_if.valid && res_if.ready) begin
				r.v[LANE_VSV] = res_if.vsv_out;
				r.v[LANE_VSH] = res_if.vsh_out;
				r.v[LANE_VPV] = res_if.vpv_out;
				r.v[LANE_VPH] = res_if.vph_out;
				r.v[LANE_RHO] = res_if.density_out;
				r.region      = res_if.region;
				r.last        = res_if.last_out;
				sb.check_result(r);
			end
		end
	end

	// receiver back-pressure in bursts
	initial begin
		int n;
		res_if.ready <= 1'b0;
		forever begin
			n = $urandom_range(1, 12);
			if (quiet || $urandom_range(0, 2) != 0) begin
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b0;
			end
			repeat (n) @(posedge clk);
		end
	end

	// one point beat, held until taken, with an optional gap first
	task automatic send_point(pt_t p);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			pt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pt_if.valid           <= 1'b1;
		pt_if.radius          <= p.radius;
		pt_if.crust_depth     <= p.crust_depth;
		pt_if.crust_shear_vel <= p.vs;
		pt_if.oceanic         <= p.oceanic;
		pt_if.vsv_in          <= p.mant[LANE_VSV];
		pt_if.vsh_in          <= p.mant[LANE_VSH];
		pt_if.vpv_in          <= p.mant[LANE_VPV];
		pt_if.vph_in          <= p.mant[LANE_VPH];
		pt_if.density_in      <= p.mant[LANE_RHO];
		pt_if.last_point      <= p.last;
		@(negedge clk);
		while (!pt_if.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// drain, let the pipe empty, then load all four registers
	task automatic load_regs(logic [23:0] er, logic [23:0] ar, logic [19:0] sl,
		logic [15:0] tf);
		pt_if.valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_we <= 1'b1; cfg_index <= CFG_EARTH_RADIUS; cfg_data <= er;
		@(posedge clk);
		cfg_index <= CFG_ANISO_RADIUS; cfg_data <= ar;
		@(posedge clk);
		cfg_index <= CFG_ANISO_SLOPE; cfg_data <= 24'(sl);
		@(posedge clk);
		cfg_index <= CFG_TAPER_FRAC; cfg_data <= 24'(tf);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.earth_r = er; sb.aniso_r = ar; sb.slope = sl; sb.frac = tf;
	endtask

	function automatic pt_t make_point(longint rad, longint dep, logic [19:0] vs,
		logic oc, logic [19:0] m, logic last);
		pt_t p;
		p.radius      = rad[23:0];
		p.crust_depth = dep[17:0];
		p.vs          = vs;
		p.oceanic     = oc;
		for (int i = 0; i < LANES; i++) p.mant[i] = m ^ 20'(i * 4099);
		p.last        = last;
		return p;
	endfunction

	// random point, mostly placed around the band
	function automatic pt_t random_point();
		pt_t    p;
		longint dep, hw, moho, rad;
		int     pick;
		pick = $urandom_range(0, 9);
		dep  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DEP_MAX)
			: $urandom_range(0, 81920);
		hw   = sb.half_width(dep);
		moho = sb.earth_r - dep;
		case (pick)
			0, 1, 2, 3, 4, 5: begin
				rad = moho + $urandom_range(0, 4 * hw + 6) - 2 * hw - 3;
			end
			6: begin
				case ($urandom_range(0, 2))
					0: rad = moho - hw;
					1: rad = moho + hw;
					default: rad = moho;
				endcase
			end
			7: rad = moho + hw + 1 + $urandom_range(0, 200000);
			8: rad = moho - hw - 1 - $urandom_range(0, 200000);
			default: rad = $urandom_range(0, RAD_MAX);
		endcase
		if (rad < 0) rad = 0;
		if (rad > RAD_MAX) rad = RAD_MAX;
		p.radius      = rad[23:0];
		p.crust_depth = dep[17:0];
		p.vs          = ($urandom_range(0, 1) == 0) ? 20'($urandom)
			: 20'($urandom_range(131072, 327680));
		p.oceanic     = $urandom_range(0, 1);
		for (int i = 0; i < LANES; i++) p.mant[i] = 20'($urandom);
		p.last        = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	initial begin
		longint dep, hw, moho;
		longint radii [8];
		sb     = new();
		quiet  = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		pt_if.valid <= 1'b0;
		pt_if.radius <= '0; pt_if.crust_depth <= '0; pt_if.crust_shear_vel <= '0;
		pt_if.oceanic <= 1'b0; pt_if.vsv_in <= '0; pt_if.vsh_in <= '0;
		pt_if.vpv_in <= '0; pt_if.vph_in <= '0; pt_if.density_in <= '0;
		pt_if.last_point <= 1'b0;
		cfg_we <= 1'b0; cfg_index <= CFG_EARTH_RADIUS; cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: band edges, zero-width band, field extremes
		dep  = 40960;
		hw   = sb.half_width(dep);
		moho = sb.earth_r - dep;
		radii = '{0, RAD_MAX, moho - hw - 1, moho - hw, moho, moho + hw, moho + hw + 1,
			sb.earth_r};
		foreach (radii[i]) begin
			send_point(make_point(radii[i], dep, 20'd229376, i[0], 20'd300000, 1'b0));
		end
		send_point(make_point(sb.earth_r, 0, 20'd200000, 1'b0, 20'd0, 1'b1));
		send_point(make_point(moho, DEP_MAX, 20'hFFFFF, 1'b1, 20'hFFFFF, 1'b0));
		send_point(make_point(moho, dep, 20'd0, 1'b0, 20'hFFFFF, 1'b1));
		send_point(make_point(moho + 7, dep, 20'hFFFFF, 1'b0, 20'd0, 1'b0));
		send_point(make_point(RAD_MAX, dep, 20'hFFFFF, 1'b1, 20'd0, 1'b1));
		send_point(make_point(0, DEP_MAX, 20'd0, 1'b1, 20'hFFFFF, 1'b0));
		send_point(make_point(sb.earth_r - 100, 0, 20'd150000, 1'b1, 20'd5, 1'b0));

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: load_regs(24'hFFFFFF, 24'd0, 20'hFFFFF, 16'hFFFF);
				2: load_regs(24'd0, 24'hFFFFFF, 20'd0, 16'd0);
				3: load_regs(24'($urandom), 24'($urandom), 20'($urandom), 16'($urandom));
				4: load_regs(RST_EARTH_RADIUS, RST_ANISO_RADIUS, RST_ANISO_SLOPE, 16'd1);
				5: begin
					load_regs(24'd6523904 + 24'($urandom_range(0, 99999)), 24'd6339584,
						20'($urandom_range(0, 80000)), 16'($urandom));
					quiet = 1'b1;
				end
				default: ;
			endcase
			repeat (305) send_point(random_point());
		end
		pt_if.valid <= 1'b0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (sb.errors == 0) begin
			$display("crust_taper_blend_tb OK");
		end else begin
			$display("crust_taper_blend_tb NOT OK");
		end
		$finish;
	end

endmodule
